/* src/cfa_pkg.sv */
package cfa_pkg;

	// Field widths fixed by the request and response formats.
	localparam int FRAME_W = 20;
	localparam int COUNT_W = 11;
	localparam int POOL_W  = 11;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 3;
	localparam int CIDX_W  = 2;
	localparam int FS_W    = 2;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REL   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_MARK  = 2'd3;

	// Response status codes.
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_COUNT = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NO_RUN    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_BOUNDS    = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_HEAD  = 3'd4;
	localparam logic [STAT_W-1:0] STAT_NOT_FREE  = 3'd5;

	// Frame states held in the store.
	localparam logic [FS_W-1:0] FS_FREE   = 2'd0;
	localparam logic [FS_W-1:0] FS_HEAD   = 2'd1;
	localparam logic [FS_W-1:0] FS_FOLLOW = 2'd2;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_BASE = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_POOL = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_RESV = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COUNT_W-1:0] count;
		logic [FRAME_W-1:0] target_frame;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] result_frame;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] free_count;
	} rsp_t;

endpackage

/* src/contiguous_frame_allocator.sv */
// First-fit contiguous frame allocator for a single pool of frames.
// Requests arrive on req (valid/stall) and each one produces exactly one
// response on rsp (valid/stall) carrying the allocated head frame, a status
// and the free frame count left after the request. Configuration registers
// are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// All frame states live in a single-port-write, registered-read store that
// a small sequencer walks one entry per cycle; the work depends on kind:
//   init:     every store entry is cleared, one per cycle
//   allocate: a scan over the active pool, then a write pass over the run
//   release:  a walk over the run's head and followers
//   mark:     a check pass over the range, then a write pass
// Failed range and count checks skip the walk and go to the finish state.
// One request is worked on at a time; req_stall is high from acceptance
// until the response has been placed in the output register.
// After reset the store is swept to all-free, and during the sweep
// req_stall stays high; configuration writes are still taken.
// The response register holds its value while rsp_stall is high, and the
// block can accept and start the next request during that time; it only
// waits for the output register when that next response is ready.
module contiguous_frame_allocator #(
	parameter int MAX_FRAMES    = 1024,
	parameter int FRAME_NO_BITS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  cfa_pkg::req_t                     req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output cfa_pkg::rsp_t                     rsp,
	input  logic                              cfg_we,
	input  logic [cfa_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [cfa_pkg::FRAME_W-1:0]       cfg_data
);

	localparam int PW       = $clog2(MAX_FRAMES + 1);
	localparam int IDXW     = $clog2(MAX_FRAMES);
	localparam int FREE_RST = (MAX_FRAMES < 1024) ? MAX_FRAMES : 1024;
	localparam logic [cfa_pkg::FRAME_W-1:0] RES_MASK =
		(FRAME_NO_BITS >= cfa_pkg::FRAME_W) ? '1 :
		cfa_pkg::FRAME_W'((64'd1 << FRAME_NO_BITS) - 64'd1);

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_ASCAN = 3'd3;
	localparam logic [2:0] ST_RWALK = 3'd4;
	localparam logic [2:0] ST_MCHK  = 3'd5;
	localparam logic [2:0] ST_WRITE = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]                      state_q;
	logic [cfa_pkg::FRAME_W-1:0]     base_q;
	logic [cfa_pkg::POOL_W-1:0]      pool_q;
	logic                            resv_q;
	cfa_pkg::req_t                   req_q;
	logic [PW-1:0]                   free_q;
	logic [PW-1:0]                   rd_q;
	logic [PW-1:0]                   lim_q;
	logic                            iss_q;
	logic                            rvld_s1;
	logic [PW-1:0]                   raddr_s1;
	logic [PW-1:0]                   run_q;
	logic [PW-1:0]                   cnt_q;
	logic [PW-1:0]                   off_q;
	logic [PW-1:0]                   wp_q;
	logic [PW-1:0]                   wrem_q;
	logic                            first_q;
	logic [cfa_pkg::FS_W-1:0]        wd_first_q;
	logic [cfa_pkg::FS_W-1:0]        wd_rest_q;
	logic                            init_q;
	logic                            res0_q;
	logic [cfa_pkg::FRAME_W-1:0]     res_frame_q;
	logic [cfa_pkg::STAT_W-1:0]      status_q;
	logic                            rsp_valid_q;
	cfa_pkg::rsp_t                   rsp_q;

	logic [cfa_pkg::POOL_W-1:0]      n_w;
	logic [PW-1:0]                   n_pw;
	logic [cfa_pkg::FRAME_W-1:0]     diff_w;
	logic                            below_w;
	logic                            st_we;
	logic [IDXW-1:0]                 st_waddr;
	logic [cfa_pkg::FS_W-1:0]        st_wdata;
	logic                            st_re;
	logic [cfa_pkg::FS_W-1:0]        st_rdata;
	logic [PW-1:0]                   run_inc;
	logic                            rsp_load;

	// Active pool size and the offset of the requested frame.
	always_comb begin
		n_w = pool_q;
		if (32'(pool_q) > MAX_FRAMES) begin
			n_w = cfa_pkg::POOL_W'(MAX_FRAMES);
		end
		n_pw    = PW'(n_w);
		below_w = req_q.target_frame < base_q;
		diff_w  = req_q.target_frame - base_q;
		run_inc = run_q + PW'(1);
	end

	// The finished response moves into the output register once it is free.
	assign rsp_load = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	// Store port control: sweeps and write passes use the write port, scans
	// use the read port, and the release walk frees entries as they return.
	always_comb begin
		st_we    = 1'b0;
		st_waddr = wp_q[IDXW-1:0];
		st_wdata = cfa_pkg::FS_FREE;
		st_re    = iss_q && (state_q == ST_ASCAN || state_q == ST_RWALK ||
			state_q == ST_MCHK);
		unique case (state_q)
			ST_CLEAR: begin
				st_we = 1'b1;
				if (wp_q == '0 && res0_q) begin
					st_wdata = cfa_pkg::FS_FOLLOW;
				end
			end
			ST_WRITE: begin
				st_we    = 1'b1;
				st_wdata = first_q ? wd_first_q : wd_rest_q;
			end
			ST_RWALK: begin
				st_waddr = raddr_s1[IDXW-1:0];
				st_we    = rvld_s1 && (first_q ? (st_rdata == cfa_pkg::FS_HEAD) :
					(st_rdata == cfa_pkg::FS_FOLLOW));
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	cfa_store #(
		.DEPTH(MAX_FRAMES),
		.AW   (IDXW)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(rd_q[IDXW-1:0]),
		.rdata(st_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			pool_q <= cfa_pkg::POOL_W'(1024);
			resv_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfa_pkg::CFG_BASE: base_q <= cfg_data;
				cfa_pkg::CFG_POOL: pool_q <= cfg_data[cfa_pkg::POOL_W-1:0];
				cfa_pkg::CFG_RESV: resv_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Read pipeline: tag each returning entry with its address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1  <= 1'b0;
			raddr_s1 <= '0;
		end else begin
			rvld_s1  <= st_re;
			raddr_s1 <= rd_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			req_q       <= '0;
			free_q      <= PW'(FREE_RST);
			rd_q        <= '0;
			lim_q       <= '0;
			iss_q       <= 1'b0;
			run_q       <= '0;
			cnt_q       <= '0;
			off_q       <= '0;
			wp_q        <= '0;
			wrem_q      <= '0;
			first_q     <= 1'b0;
			wd_first_q  <= cfa_pkg::FS_FREE;
			wd_rest_q   <= cfa_pkg::FS_FREE;
			init_q      <= 1'b0;
			res0_q      <= 1'b0;
			res_frame_q <= '0;
			status_q    <= cfa_pkg::STAT_OK;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (st_re) begin
				rd_q <= rd_q + PW'(1);
				if (rd_q == lim_q) begin
					iss_q <= 1'b0;
				end
			end
			unique case (state_q)
				// Sweep the whole store, after reset or for an init request.
				ST_CLEAR: begin
					wp_q <= wp_q + PW'(1);
					if (wp_q == PW'(MAX_FRAMES - 1)) begin
						state_q <= init_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= ST_CHECK;
					end
				end
				// Range and count checks, then pick the walk for this kind.
				ST_CHECK: begin
					status_q    <= cfa_pkg::STAT_OK;
					res_frame_q <= '0;
					run_q       <= '0;
					first_q     <= 1'b1;
					cnt_q       <= PW'(req_q.count);
					off_q       <= PW'(diff_w);
					unique case (req_q.kind)
						cfa_pkg::KIND_INIT: begin
							init_q  <= 1'b1;
							res0_q  <= resv_q && (n_w != '0);
							free_q  <= (resv_q && (n_w != '0)) ? n_pw - PW'(1) : n_pw;
							wp_q    <= '0;
							state_q <= ST_CLEAR;
						end
						cfa_pkg::KIND_ALLOC: begin
							if (req_q.count == '0 || req_q.count > n_w) begin
								status_q <= cfa_pkg::STAT_BAD_COUNT;
								state_q  <= ST_FIN;
							end else if (32'(req_q.count) > 32'(free_q)) begin
								status_q <= cfa_pkg::STAT_NO_RUN;
								state_q  <= ST_FIN;
							end else begin
								rd_q    <= '0;
								lim_q   <= n_pw - PW'(1);
								iss_q   <= 1'b1;
								state_q <= ST_ASCAN;
							end
						end
						cfa_pkg::KIND_REL: begin
							if (below_w || diff_w >= cfa_pkg::FRAME_W'(n_w)) begin
								status_q <= cfa_pkg::STAT_BOUNDS;
								state_q  <= ST_FIN;
							end else begin
								rd_q    <= PW'(diff_w);
								lim_q   <= n_pw - PW'(1);
								iss_q   <= 1'b1;
								state_q <= ST_RWALK;
							end
						end
						default: begin
							if (req_q.count == '0) begin
								status_q <= cfa_pkg::STAT_BAD_COUNT;
								state_q  <= ST_FIN;
							end else if (below_w || (21'(diff_w) + 21'(req_q.count) >
								21'(n_w))) begin
								status_q <= cfa_pkg::STAT_BOUNDS;
								state_q  <= ST_FIN;
							end else begin
								rd_q    <= PW'(diff_w);
								lim_q   <= PW'(diff_w) + PW'(req_q.count) - PW'(1);
								iss_q   <= 1'b1;
								state_q <= ST_MCHK;
							end
						end
					endcase
				end
				// First-fit scan: count consecutive free entries.
				ST_ASCAN: begin
					if (rvld_s1) begin
						if (st_rdata == cfa_pkg::FS_FREE && run_inc == cnt_q) begin
							wp_q       <= raddr_s1 + PW'(1) - cnt_q;
							wrem_q     <= cnt_q;
							wd_first_q <= cfa_pkg::FS_HEAD;
							wd_rest_q  <= cfa_pkg::FS_FOLLOW;
							state_q    <= ST_WRITE;
						end else if (raddr_s1 == lim_q) begin
							status_q <= cfa_pkg::STAT_NO_RUN;
							state_q  <= ST_FIN;
						end else begin
							run_q <= (st_rdata == cfa_pkg::FS_FREE) ? run_inc : '0;
						end
					end
				end
				// Release walk: free the head, then the followers behind it.
				ST_RWALK: begin
					if (rvld_s1) begin
						if (st_we) begin
							first_q <= 1'b0;
							if (free_q < PW'(MAX_FRAMES)) begin
								free_q <= free_q + PW'(1);
							end
							if (raddr_s1 == lim_q) begin
								state_q <= ST_FIN;
							end
						end else begin
							state_q <= ST_FIN;
							if (first_q) begin
								status_q <= cfa_pkg::STAT_NOT_HEAD;
							end
						end
					end
				end
				// Mark check: every frame of the range must be free.
				ST_MCHK: begin
					if (rvld_s1) begin
						if (st_rdata != cfa_pkg::FS_FREE) begin
							status_q <= cfa_pkg::STAT_NOT_FREE;
							state_q  <= ST_FIN;
						end else if (raddr_s1 == lim_q) begin
							wp_q       <= off_q;
							wrem_q     <= cnt_q;
							wd_first_q <= cfa_pkg::FS_HEAD;
							wd_rest_q  <= cfa_pkg::FS_HEAD;
							state_q    <= ST_WRITE;
						end
					end
				end
				// Write pass over a run, one entry per cycle.
				ST_WRITE: begin
					if (first_q && req_q.kind == cfa_pkg::KIND_ALLOC) begin
						res_frame_q <= (base_q + cfa_pkg::FRAME_W'(wp_q)) & RES_MASK;
					end
					first_q <= 1'b0;
					wp_q    <= wp_q + PW'(1);
					wrem_q  <= wrem_q - PW'(1);
					if (free_q != '0) begin
						free_q <= free_q - PW'(1);
					end
					if (wrem_q == PW'(1)) begin
						state_q <= ST_FIN;
					end
				end
				// Hand the response to the output register once it is free.
				default: begin
					if (rsp_load) begin
						rsp_q.result_frame <= res_frame_q;
						rsp_q.status       <= status_q;
						rsp_q.free_count   <= cfa_pkg::COUNT_W'(free_q);
						init_q             <= 1'b0;
						state_q            <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The free counter never exceeds the store depth.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= PW'(MAX_FRAMES))
		else $error("free frame counter above store depth");

	// An accepted request blocks the next one in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request channel open right after acceptance");

	// A response only appears out of the finish state.
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("response raised outside the finish state");

	// Store writes only happen in the sweep, write pass or release walk.
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (state_q == ST_CLEAR || state_q == ST_WRITE ||
			state_q == ST_RWALK))
		else $error("store write in an unexpected state");

endmodule

/* src/cfa_store.sv */
module cfa_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [cfa_pkg::FS_W-1:0] wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [cfa_pkg::FS_W-1:0] rdata
);

	logic [cfa_pkg::FS_W-1:0] mem [DEPTH];
	logic [cfa_pkg::FS_W-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
